FILE: rtl/core/mmtt_pkg.sv
// ============================================================================
// mmtt_pkg: shared definitions of the memory mapped text terminal
// Geometry of the character store, bus window constants, command codes and
// the command and status groups between controller and datapath.
// ============================================================================
package mmtt_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int STORE_DEPTH = COLUMNS * ROWS;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  // The cursor index row*COLUMNS+column can reach 255*COLUMNS+255.
  localparam int IDX_W       = $clog2(255 * COLUMNS + 256);

  localparam logic [7:0] COLUMNS_B = 8'(COLUMNS);
  localparam logic [7:0] ROWS_B    = 8'(ROWS);
  localparam logic [7:0] BLANK     = 8'h20;

  localparam logic [15:0] WINDOW_BASE = 16'hC000;
  localparam logic [15:0] WINDOW_LAST = 16'hC000 + 16'd8191;

  // Write offsets decode the full distance from the window base.
  localparam logic [15:0] WR_OFF_CHAR = 16'd0;
  localparam logic [15:0] WR_OFF_ROW  = 16'd1;
  localparam logic [15:0] WR_OFF_COL  = 16'd2;

  // Read offsets decode the low two address bits only.
  localparam logic [1:0] RD_OFF_CHAR = 2'd0;
  localparam logic [1:0] RD_OFF_COL  = 2'd1;
  localparam logic [1:0] RD_OFF_ROW  = 2'd2;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic load_item;
    logic calc_index;
    logic exec;
    logic load_out;
    logic clear_step;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t item_cmd;
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/core/mmtt_req_if.sv
// ============================================================================
// mmtt_req_if: request channel of the text terminal
// Carries one bus access or clear command per beat with valid and ready.
// ============================================================================
interface mmtt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] bus_address;
  logic [7:0]  write_byte;

  modport source (output valid, output cmd, output bus_address, output write_byte,
                  input ready);
  modport sink   (input valid, input cmd, input bus_address, input write_byte,
                  output ready);
endinterface

FILE: rtl/core/mmtt_rsp_if.sv
// ============================================================================
// mmtt_rsp_if: response channel of the text terminal
// Carries the data byte of one bus read per beat with valid and ready.
// ============================================================================
interface mmtt_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;

  modport source (output valid, output read_byte, input ready);
  modport sink   (input valid, input read_byte, output ready);
endinterface

FILE: rtl/core/memory_mapped_text_terminal.sv
// ============================================================================
// memory_mapped_text_terminal: bus mapped character terminal
// A COLUMNS x ROWS character store with a cursor, reached through a 16-bit
// bus window at 0xC000, plus a command that blanks the whole store.
// ============================================================================
//
//   channel  direction  beat contents                       handshake
//   -------  ---------  ----------------------------------  -----------
//   req      in         cmd, bus_address, write_byte        valid/ready
//   rsp      out        read_byte (one beat per bus read)   valid/ready
//
// A bus write steps through latch, cursor index multiply and store access from
// acceptance to the next acceptance, and a bus read adds a result load.
// Command code 3 is accepted and goes no further than the latch.
// A clear walks the store one entry per cycle, over all STORE_DEPTH entries.
// After reset the same pass runs, during which req.ready is low.
// The result sits in an output register, so writes keep flowing while a read
// beat waits on rsp.ready; a later read holds in its result phase until the
// register is free.
//
// The block is split into a sequencer (mmtt_ctrl) and a datapath
// (mmtt_datapath) that share only the request command code, a command group
// and a status group. Read offsets within the window mirror every four bytes:
// character under the cursor, cursor column, cursor row, then zero. Write
// offsets are decoded exactly: offset 0 stores a character and advances the
// cursor, offset 1 sets the row and offset 2 sets the column. A cursor that
// points past the store reads as zero and drops character writes.
module memory_mapped_text_terminal
  import mmtt_pkg::*;
(
  input logic   clk,
  input logic   rst,
  mmtt_req_if.sink   req,
  mmtt_rsp_if.source rsp
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // The sequencer sees only the request handshake and the incoming command
  // code, which it needs to pick the first phase of an accepted item.
  mmtt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (cmd_t'(req.cmd)),
    .req_ready (req.ready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  // The datapath latches the payload of an accepted beat and drives the
  // response channel from its output register.
  mmtt_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (dp_cmd),
    .status          (dp_status),
    .req_cmd         (req.cmd),
    .req_bus_address (req.bus_address),
    .req_write_byte  (req.write_byte),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .read_byte       (rsp.read_byte)
  );

endmodule

FILE: rtl/core/mmtt_ctrl.sv
// ============================================================================
// mmtt_ctrl: sequencer of the text terminal
// Accepts one request at a time, steps a bus access through index and execute
// phases, plus a result phase for a read, and walks the store during a clear.
// ============================================================================
module mmtt_ctrl
  import mmtt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  cmd_t       req_cmd,
  output logic       req_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_EXEC,
    ST_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          case (req_cmd)
            CMD_CLEAR: state_next = ST_CLEAR;
            CMD_READ:  state_next = ST_INDEX;
            CMD_WRITE: state_next = ST_INDEX;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_INDEX: state_next = ST_EXEC;
      ST_EXEC: begin
        state_next = (status.item_cmd == CMD_READ) ? ST_RESULT : ST_IDLE;
      end
      ST_RESULT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready      = (state == ST_IDLE);
  assign cmd.load_item  = (state == ST_IDLE) && req_valid;
  assign cmd.calc_index = (state == ST_INDEX);
  assign cmd.exec       = (state == ST_EXEC);
  assign cmd.load_out   = (state == ST_RESULT) && status.out_free;
  assign cmd.clear_step = (state == ST_CLEAR);

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_item, cmd.calc_index, cmd.exec, cmd.load_out, cmd.clear_step}))
    else $error("controller issued more than one datapath command");

  a_exec_after_index: assert property (@(posedge clk) disable iff (rst)
    cmd.calc_index |=> cmd.exec)
    else $error("execute phase did not follow index phase");

endmodule

FILE: rtl/core/mmtt_datapath.sv
// ============================================================================
// mmtt_datapath: store, cursor and result register of the text terminal
// Holds the latched request, the cursor, the character store and the
// output register, and acts on the controller's commands.
// ============================================================================
module mmtt_datapath
  import mmtt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  logic [1:0]  req_cmd,
  input  logic [15:0] req_bus_address,
  input  logic [7:0]  req_write_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_byte
);

  cmd_t              item_cmd;
  logic [15:0]       item_addr;
  logic [7:0]        item_data;
  logic [7:0]        cursor_column;
  logic [7:0]        cursor_row;
  logic [IDX_W-1:0]  idx;
  logic              idx_ok;
  logic [7:0]        rd_data;
  logic [ADDR_W-1:0] clear_cnt;
  logic [7:0]        store [STORE_DEPTH];

  logic [IDX_W-1:0]  idx_next;
  logic              in_window;
  logic [15:0]       wr_offset;
  logic              is_write;
  logic              store_we;
  logic              store_re;
  logic [ADDR_W-1:0] store_waddr;
  logic [7:0]        store_wdata;
  logic [7:0]        col_inc;
  logic [7:0]        row_inc;
  logic [7:0]        read_value;
  logic              clear_last;
  logic              out_free;

  assign idx_next   = IDX_W'(cursor_row) * IDX_W'(COLUMNS) + IDX_W'(cursor_column);
  assign in_window  = (item_addr >= WINDOW_BASE) && (item_addr <= WINDOW_LAST);
  assign wr_offset  = item_addr - WINDOW_BASE;
  assign is_write   = cmd.exec && (item_cmd == CMD_WRITE) && in_window;
  assign clear_last = (clear_cnt == ADDR_W'(STORE_DEPTH - 1));
  assign out_free   = !out_valid || out_ready;
  assign col_inc    = cursor_column + 8'd1;
  assign row_inc    = cursor_row + 8'd1;

  assign store_we    = cmd.clear_step || (is_write && (wr_offset == WR_OFF_CHAR) && idx_ok);
  assign store_re    = cmd.exec && (item_cmd == CMD_READ) && idx_ok;
  assign store_waddr = cmd.clear_step ? clear_cnt : idx[ADDR_W-1:0];
  assign store_wdata = cmd.clear_step ? BLANK : item_data;

  always_comb begin
    read_value = 8'd0;
    if (in_window) begin
      case (item_addr[1:0])
        RD_OFF_CHAR: read_value = idx_ok ? rd_data : 8'd0;
        RD_OFF_COL:  read_value = cursor_column;
        RD_OFF_ROW:  read_value = cursor_row;
        default:     read_value = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) store[store_waddr] <= store_wdata;
    if (store_re) rd_data <= store[idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_cmd  <= cmd_t'(req_cmd);
      item_addr <= req_bus_address;
      item_data <= req_write_byte;
    end
    if (cmd.calc_index) begin
      idx    <= idx_next;
      idx_ok <= (idx_next < IDX_W'(STORE_DEPTH));
    end
    if (cmd.load_out) read_byte <= read_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= 8'd0;
      cursor_row    <= 8'd0;
      clear_cnt     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (is_write) begin
        case (wr_offset)
          WR_OFF_CHAR: begin
            if (col_inc >= COLUMNS_B) begin
              cursor_column <= 8'd0;
              cursor_row    <= (row_inc >= ROWS_B) ? 8'd0 : row_inc;
            end else begin
              cursor_column <= col_inc;
            end
          end
          WR_OFF_ROW: cursor_row    <= item_data;
          WR_OFF_COL: cursor_column <= item_data;
          default: ;
        endcase
      end
      if (cmd.load_item) begin
        clear_cnt <= '0;
      end else if (cmd.clear_step) begin
        clear_cnt <= clear_last ? '0 : clear_cnt + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.item_cmd   = item_cmd;
  assign status.clear_last = clear_last;
  assign status.out_free   = out_free;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register loaded while a result was pending");

  a_clear_bound: assert property (@(posedge clk) disable iff (rst)
    clear_cnt < ADDR_W'(STORE_DEPTH))
    else $error("clear counter ran past the store");

  a_advance_wraps: assert property (@(posedge clk) disable iff (rst)
    (is_write && (wr_offset == WR_OFF_CHAR)) |=> (cursor_column < COLUMNS_B))
    else $error("cursor column not wrapped after a character write");

endmodule
